// File: hdl/wsup_pkg.sv
// ============================================================================
// wsup_pkg : shared types and constants for the wide string parser
// Request/result structs, character codes, base codes and digit decode.
// ============================================================================
package wsup_pkg;

    // Fixed field widths
    localparam int CH_W       = 21;
    localparam int VALUE_W    = 64;
    localparam int END_W      = 13;
    localparam int BASE_W     = 6;

    // Default parameter values
    localparam int DEF_MAX_LEN    = 4096;
    localparam int DEF_VALUE_BITS = VALUE_W;

    // Base codes
    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
    localparam logic [BASE_W-1:0] BASE_DEFAULT = BASE_DEC;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 21'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 21'd9;
    localparam logic [CH_W-1:0] CH_CR    = 21'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 21'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 21'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 21'd45;
    localparam logic [CH_W-1:0] CH_DIG0  = 21'd48;
    localparam logic [CH_W-1:0] CH_DIG9  = 21'd57;
    localparam logic [CH_W-1:0] CH_UP_A  = 21'd65;
    localparam logic [CH_W-1:0] CH_UP_X  = 21'd88;
    localparam logic [CH_W-1:0] CH_UP_Z  = 21'd90;
    localparam logic [CH_W-1:0] CH_LO_A  = 21'd97;
    localparam logic [CH_W-1:0] CH_LO_X  = 21'd120;
    localparam logic [CH_W-1:0] CH_LO_Z  = 21'd122;

    // Offsets from a character code to its digit value
    localparam logic [CH_W-1:0] OFS_UPPER = 21'd55;
    localparam logic [CH_W-1:0] OFS_LOWER = 21'd87;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_LEAD   = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_XPFX   = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
    } t_char_req;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               range_error;
        logic [END_W-1:0]   end_index;
    } t_parse_res;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] val;
    } t_digit;

    // Decode one character as a digit of base b
    function automatic t_digit digit_of(input logic [CH_W-1:0] c,
                                        input logic [BASE_W-1:0] b);
        t_digit r;
        logic   is_dig;
        r      = '0;
        is_dig = 1'b1;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r.val = BASE_W'(c - OFS_UPPER);
        end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            r.val = BASE_W'(c - OFS_LOWER);
        end else if (c inside {[CH_DIG0:CH_DIG9]}) begin
            r.val = BASE_W'(c - CH_DIG0);
        end else begin
            is_dig = 1'b0;
        end
        r.ok = is_dig && (b >= BASE_MIN) && (b <= BASE_MAX) && (r.val < b);
        return r;
    endfunction

endpackage

// File: hdl/wsup_in_reg.sv
// ============================================================================
// wsup_in_reg : input register stage
// Captures one character request; holds it while the step stage is blocked.
// ============================================================================
module wsup_in_reg
    import wsup_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_char_req i_req,
    input  logic      i_out_ready,
    output logic      o_valid,
    output t_char_req o_req
);

    logic      r_valid;
    t_char_req r_req;

    // Blocked only when a held request cannot move on
    assign o_stall = r_valid && !i_out_ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// File: hdl/wsup_core.sv
// ============================================================================
// wsup_core : per-character parse step
// Holds the parse state and the base register; one multiply-add per request.
// ============================================================================
module wsup_core
    import wsup_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BASE_W-1:0] i_cfg_wr_data,
    input  logic              i_fire,
    input  t_char_req         i_req,
    output logic              o_res_valid,
    output t_parse_res        o_res
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int MAC_W = VALUE_BITS + BASE_W + 1;

    // State registers
    logic [BASE_W-1:0]     r_cfg_base;
    t_phase                r_phase;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_neg;
    logic [BASE_W-1:0]     r_eb;
    logic                  r_ovf;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_lde;

    // Next values
    t_phase                n_phase;
    logic [VALUE_BITS-1:0] n_acc;
    logic                  n_neg;
    logic [BASE_W-1:0]     n_eb;
    logic                  n_ovf;
    logic [POS_W-1:0]      n_pos;
    logic [POS_W-1:0]      n_lde;

    // State seen by this request (a new string restarts it)
    t_phase                p_phase;
    logic [VALUE_BITS-1:0] p_acc;
    logic                  p_neg;
    logic [BASE_W-1:0]     p_eb;
    logic                  p_ovf;
    logic [POS_W-1:0]      p_pos;
    logic [POS_W-1:0]      p_lde;

    logic [CH_W-1:0]       ch;
    logic [POS_W-1:0]      pos_inc;
    logic                  emit;
    logic                  signed_path;
    logic                  do_dig;
    logic [BASE_W-1:0]     step_base;
    t_digit                dig;
    logic [MAC_W-2:0]      prod;
    logic [MAC_W-1:0]      mac;
    logic                  mac_ovf;
    logic [VALUE_BITS-1:0] fin_val;
    logic [POS_W+END_W-1:0] lde_ext;

    assign ch = i_req.ch;

    // Restart on the first character of a string
    always_comb begin
        if (i_req.first) begin
            p_phase = PH_LEAD;
            p_acc   = '0;
            p_neg   = 1'b0;
            p_eb    = r_cfg_base;
            p_ovf   = 1'b0;
            p_pos   = '0;
            p_lde   = '0;
        end else begin
            p_phase = r_phase;
            p_acc   = r_acc;
            p_neg   = r_neg;
            p_eb    = r_eb;
            p_ovf   = r_ovf;
            p_pos   = r_pos;
            p_lde   = r_lde;
        end
    end

    assign pos_inc = p_pos + POS_W'(1);

    // Step logic: phase decode, digit decode, multiply-add
    always_comb begin
        n_phase     = p_phase;
        n_acc       = p_acc;
        n_neg       = p_neg;
        n_eb        = p_eb;
        n_ovf       = p_ovf;
        n_pos       = p_pos;
        n_lde       = p_lde;
        emit        = 1'b0;
        signed_path = 1'b0;
        do_dig      = 1'b0;
        step_base   = p_eb;

        if (p_phase != PH_IDLE) begin
            if (ch == CH_NUL || p_pos >= POS_W'(MAX_LEN)) begin
                emit    = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                case (p_phase)
                    PH_LEAD: begin
                        if (ch == CH_SPACE || ch inside {[CH_TAB:CH_CR]}) begin
                            n_pos = pos_inc;
                        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                            n_neg   = (ch == CH_MINUS);
                            n_phase = PH_SIGNED;
                            n_pos   = pos_inc;
                        end else begin
                            signed_path = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        signed_path = 1'b1;
                    end
                    PH_ZERO: begin
                        if (ch == CH_LO_X || ch == CH_UP_X) begin
                            n_eb    = BASE_HEX;
                            n_phase = PH_XPFX;
                            n_pos   = pos_inc;
                        end else begin
                            step_base = (p_eb == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                            n_eb      = step_base;
                            do_dig    = 1'b1;
                        end
                    end
                    PH_XPFX, PH_DIGITS: begin
                        do_dig = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                // Sign taken or absent: look for a leading zero
                if (signed_path) begin
                    if (ch == CH_DIG0 && (p_eb == BASE_AUTO || p_eb == BASE_HEX)) begin
                        n_acc   = '0;
                        n_lde   = pos_inc;
                        n_phase = PH_ZERO;
                        n_pos   = pos_inc;
                    end else begin
                        step_base = (p_eb == BASE_AUTO) ? BASE_DEC : p_eb;
                        n_eb      = step_base;
                        do_dig    = 1'b1;
                    end
                end
            end
        end

        // Digit decode and exact overflow test on acc * base + digit
        dig     = digit_of(ch, step_base);
        prod    = {{BASE_W{1'b0}}, p_acc} * {{VALUE_BITS{1'b0}}, step_base};
        mac     = {1'b0, prod} + {{(VALUE_BITS + 1){1'b0}}, dig.val};
        mac_ovf = |mac[MAC_W-1:VALUE_BITS];

        if (do_dig) begin
            if (!dig.ok) begin
                emit    = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                if (!p_ovf) begin
                    if (mac_ovf) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = mac[VALUE_BITS-1:0];
                    end
                end
                n_lde   = pos_inc;
                n_phase = PH_DIGITS;
                n_pos   = pos_inc;
            end
        end
    end

    // Result formatting
    always_comb begin
        if (p_ovf) begin
            fin_val = '1;
        end else if (p_neg) begin
            fin_val = ~p_acc + VALUE_BITS'(1);
        end else begin
            fin_val = p_acc;
        end
        lde_ext = {{END_W{1'b0}}, p_lde};
        o_res   = '0;
        if (p_lde != '0) begin
            o_res.value       = VALUE_W'(fin_val);
            o_res.range_error = p_ovf;
            o_res.end_index   = lde_ext[END_W-1:0];
        end
    end

    assign o_res_valid = emit;

    // Base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= BASE_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_cfg_base <= i_cfg_wr_data;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_eb    <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_lde   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_eb    <= n_eb;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_lde   <= n_lde;
        end
    end

    // Checks
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid |=> r_phase == PH_IDLE)
        else $error("string still open after its result");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_LEN))
        else $error("position beyond length limit");

    a_ovf_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_lde != '0)
        else $error("overflow without any digit");

    a_range_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.range_error |-> o_res.value == VALUE_W'(p_acc | '1))
        else $error("overflow result not saturated");

    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.end_index == '0 && p_lde == '0
            |-> o_res.value == '0 && !o_res.range_error)
        else $error("empty conversion gives nonzero result");

endmodule

// File: hdl/wsup_out_reg.sv
// ============================================================================
// wsup_out_reg : result register
// Holds one finished result until the consumer takes it.
// ============================================================================
module wsup_out_reg
    import wsup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_parse_res i_res,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output t_parse_res o_res
);

    logic       r_valid;
    t_parse_res r_res;

    // Free when empty or being drained this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/wide_string_to_unsigned_parser_top.sv
// A result is loaded into the result register by the request holding its ending
// character, from the input register. Throughput: one character per cycle while
// the result side does not stall; the step is one multiply-add on the accumulator
// between the input register and the result register. Reset (synchronous, active
// low) ends any open string, empties both registers, sets the conversion base to 10.
// ============================================================================
// wide_string_to_unsigned_parser_top : streaming string to unsigned parser
// Input register, parse step with state, result register.
// ============================================================================
module wide_string_to_unsigned_parser_top
    import wsup_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BASE_W-1:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_char_req         i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output t_parse_res        o_res
);

    logic       in_valid;
    t_char_req  in_req;
    logic       out_ready;
    logic       fire;
    logic       res_valid;
    t_parse_res res;

    // Step advances when a request is held and the result side has room
    assign fire = in_valid && out_ready;

    wsup_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .i_out_ready (out_ready),
        .o_valid     (in_valid),
        .o_req       (in_req)
    );

    wsup_core #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_req         (in_req),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    wsup_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

// File: tb/tb_wide_string_to_unsigned_parser_top.sv
// ============================================================================
// tb_wide_string_to_unsigned_parser_top : self-checking bench for the parser
// Streams characters through the parser under several base settings and
// handshake pressure, predicts each conversion result in the bench and
// compares every result received against the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module tb_wide_string_to_unsigned_parser_top;
    import wsup_pkg::*;

    localparam int                STR_MAX        = DEF_MAX_LEN;
    localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;
    localparam logic [CH_W-1:0]   MAX_CODE       = 21'h10FFFF;
    localparam logic [BASE_W-1:0] BASE_BAD_LOW   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_BAD_HIGH  = 6'd37;
    localparam logic [BASE_W-1:0] BASE_TOP       = 6'd63;
    localparam int                NUM_PHASES     = 12;
    localparam int                PHASE_CHARS    = 120;
    localparam int                DRAIN_CYCLES   = 8;
    localparam int                WATCHDOG_LIMIT = 5000;

    // Clock, reset and block ports
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [BASE_W-1:0] i_cfg_wr_data = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    t_char_req         i_req         = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    t_parse_res        o_res;

    // Stimulus and checking state
    t_char_req   char_queue[$];
    t_parse_res  result_queue[$];
    bit          req_taken      = 1'b0;
    bit          next_first     = 1'b0;
    int          str_chars      = 0;
    int          fail_count     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    logic [BASE_W-1:0] phase_base [NUM_PHASES];

    // Parser state mirrored in the bench
    logic [BASE_W-1:0]  base_reg    = BASE_DEFAULT;
    t_phase             st_phase    = PH_IDLE;
    logic [VALUE_W-1:0] st_acc      = '0;
    bit                 st_neg      = 1'b0;
    logic [BASE_W-1:0]  st_base     = '0;
    bit                 st_ovf      = 1'b0;
    int                 st_pos      = 0;
    int                 st_last_end = 0;

    wide_string_to_unsigned_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req         (i_req),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_res         (o_res)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Digit value of a character in base b in d; returns 0 when it is no digit there
    function automatic bit char_digit(input logic [CH_W-1:0] c,
                                      input logic [BASE_W-1:0] b,
                                      output int unsigned d);
        d = 0;
        if (b < BASE_MIN || b > BASE_MAX) return 1'b0;
        if (c >= CH_UP_A && c <= CH_UP_Z) d = c - CH_UP_A + 10;
        else if (c >= CH_LO_A && c <= CH_LO_Z) d = c - CH_LO_A + 10;
        else if (c >= CH_DIG0 && c <= CH_DIG9) d = c - CH_DIG0;
        else return 1'b0;
        return d < b;
    endfunction

    // Result of the open string; closes it
    function automatic t_parse_res close_string();
        t_parse_res r;
        r = '0;
        if (st_last_end != 0) begin
            if (st_ovf) r.value = VALUE_ALL_ONES;
            else r.value = st_neg ? (~st_acc + 64'd1) : st_acc;
            r.range_error = st_ovf;
            r.end_index   = END_W'(st_last_end);
        end
        st_phase = PH_IDLE;
        return r;
    endfunction

    // Advance the mirrored parser by one character; 1 when a result is due
    function automatic bit parse_char(input logic [CH_W-1:0] c, input logic first,
                                      output t_parse_res r);
        bit          take_digit;
        int unsigned d;
        r          = '0;
        take_digit = 1'b0;
        if (first) begin
            st_phase    = PH_LEAD;
            st_acc      = '0;
            st_neg      = 1'b0;
            st_base     = base_reg;
            st_ovf      = 1'b0;
            st_pos      = 0;
            st_last_end = 0;
        end
        if (st_phase == PH_IDLE) return 1'b0;
        if (c == CH_NUL || st_pos >= STR_MAX) begin
            r = close_string();
            return 1'b1;
        end
        case (st_phase)
            PH_LEAD, PH_SIGNED: begin
                if (st_phase == PH_LEAD && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    // leading whitespace skipped
                end else if (st_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                    st_neg   = (c == CH_MINUS);
                    st_phase = PH_SIGNED;
                end else if (c == CH_DIG0 && (st_base == BASE_AUTO || st_base == BASE_HEX)) begin
                    st_acc      = '0;
                    st_last_end = st_pos + 1;
                    st_phase    = PH_ZERO;
                end else begin
                    if (st_base == BASE_AUTO) st_base = BASE_DEC;
                    take_digit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    st_base  = BASE_HEX;
                    st_phase = PH_XPFX;
                end else begin
                    st_base    = (st_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    take_digit = 1'b1;
                end
            end
            default: take_digit = 1'b1;
        endcase
        if (take_digit) begin
            if (!char_digit(c, st_base, d)) begin
                r = close_string();
                return 1'b1;
            end
            // exact overflow test before the multiply-add
            if (!st_ovf) begin
                if (st_acc > (VALUE_ALL_ONES - 64'(d)) / 64'(st_base)) st_ovf = 1'b1;
                else st_acc = st_acc * 64'(st_base) + 64'(d);
            end
            st_last_end = st_pos + 1;
            st_phase    = PH_DIGITS;
        end
        st_pos++;
        return 1'b0;
    endfunction

    // Character for digit value d, letters in random case
    function automatic logic [CH_W-1:0] digit_char(input int unsigned d);
        if (d < 10) return CH_W'(CH_DIG0 + d);
        return CH_W'((($urandom_range(0, 1) == 0) ? CH_UP_A : CH_LO_A) + d - 10);
    endfunction

    task automatic push_char(input logic [CH_W-1:0] c);
        char_queue.push_back(t_char_req'{ch: c, first: next_first});
        next_first = 1'b0;
        str_chars++;
    endtask

    task automatic open_string(input logic [CH_W-1:0] c);
        next_first = 1'b1;
        push_char(c);
    endtask

    // Character with no string marker, outside any open string
    task automatic push_stray(input logic [CH_W-1:0] c);
        char_queue.push_back(t_char_req'{ch: c, first: 1'b0});
    endtask

    // Well-formed number with random whitespace, sign, prefix, digits, end
    task automatic push_number(input logic [BASE_W-1:0] base);
        int unsigned        eff;
        int unsigned        ndig;
        int unsigned        pick;
        int unsigned        d;
        int                 i;
        logic [VALUE_W-1:0] v;
        bit                 boundary;
        bit                 dec_auto;
        next_first = 1'b1;
        boundary   = 1'b0;
        dec_auto   = 1'b0;
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0) begin
            pick = $urandom_range(0, 5);
            push_char((pick == 0) ? CH_SPACE : CH_W'(CH_TAB + pick - 1));
        end
        pick = $urandom_range(0, 3);
        if (pick == 1) push_char(CH_PLUS);
        else if (pick == 2) push_char(CH_MINUS);
        // prefix and the base the digits are drawn from
        eff = base;
        if (base == BASE_AUTO) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                push_char(CH_DIG0);
                push_char(($urandom_range(0, 1) == 0) ? CH_LO_X : CH_UP_X);
                eff = BASE_HEX;
            end else if (pick == 1) begin
                push_char(CH_DIG0);
                eff = BASE_OCT;
            end else begin
                eff      = BASE_DEC;
                dec_auto = 1'b1;
            end
        end else if (base == BASE_HEX && $urandom_range(0, 2) == 0) begin
            push_char(CH_DIG0);
            push_char(($urandom_range(0, 1) == 0) ? CH_LO_X : CH_UP_X);
        end else if (base < BASE_MIN || base > BASE_MAX) begin
            eff = BASE_MAX;
        end
        // digit count: none, around the overflow point, long, or short
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            ndig = 0;
        end else if (pick == 1) begin
            boundary = 1'b1;
            v        = VALUE_ALL_ONES;
            ndig     = 0;
            while (v != 0) begin
                v = v / eff;
                ndig++;
            end
            ndig = ndig - 1 + $urandom_range(0, 2);
        end else if (pick == 2) begin
            ndig = $urandom_range(10, 70);
        end else begin
            ndig = $urandom_range(1, 8);
        end
        for (i = 0; i < ndig; i++) begin
            if (boundary) d = eff - 1;
            else if (dec_auto && i == 0) d = $urandom_range(1, 9);
            else d = $urandom_range(0, eff - 1);
            push_char(digit_char(d));
        end
        // end of string; when left open the next string restarts it
        pick = $urandom_range(0, 9);
        if (pick <= 3) push_char(CH_NUL);
        else if (pick <= 5) push_char(CH_W'($urandom_range(0, 127)));
        else if (pick == 6) push_char(CH_W'($urandom_range(0, MAX_CODE)));
        else if (pick == 7 && eff < BASE_MAX) push_char(digit_char(eff));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_stray(CH_W'($urandom_range(0, 127)));
    endtask

    // Random characters, ASCII or any code point up to MAX_CODE in equal parts
    task automatic push_noise();
        next_first = 1'b1;
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0) push_char(CH_W'($urandom_range(0, 127)));
            else push_char(CH_W'($urandom_range(0, MAX_CODE)));
        end
    endtask

    // Wait until every request is in and every result out, then let the pipe empty
    task automatic wait_drained();
        while (char_queue.size() != 0 || i_valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        base_reg = b;
    endtask

    // Request driver: holds a request until taken, idles at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req   <= '0;
        end else if (!i_valid || req_taken) begin
            if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_req   <= char_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: predict on each taken request, check each taken result
    always @(posedge i_clk) begin : result_monitor
        t_parse_res predicted;
        t_parse_res wanted;
        bit         res_taken;
        if (!i_rst_n) begin
            req_taken    = 1'b0;
            quiet_cycles = 0;
            base_reg     = BASE_DEFAULT;
            st_phase     = PH_IDLE;
        end else begin
            req_taken = i_valid && !o_stall;
            res_taken = o_valid && !i_stall;
            if (req_taken) begin
                if (parse_char(i_req.ch, i_req.first, predicted))
                    result_queue.push_back(predicted);
            end
            if (res_taken) begin
                if (result_queue.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result value=%h range_error=%b end_index=%0d",
                             $time, o_res.value, o_res.range_error, o_res.end_index);
                end else begin
                    wanted = result_queue.pop_front();
                    if (o_res.value !== wanted.value
                        || o_res.range_error !== wanted.range_error
                        || o_res.end_index !== wanted.end_index) begin
                        fail_count++;
                        $display("%0t: mismatch expected value=%h range_error=%b end_index=%0d",
                                 $time, wanted.value, wanted.range_error, wanted.end_index);
                        $display("%0t:          actual   value=%h range_error=%b end_index=%0d",
                                 $time, o_res.value, o_res.range_error, o_res.end_index);
                    end
                end
            end
            // watchdog on handshake progress
            if (req_taken || res_taken) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int p;
        int target;
        phase_base = '{BASE_AUTO, BASE_MIN, BASE_OCT, BASE_HEX, BASE_MAX, BASE_BAD_LOW,
                       BASE_TOP, BASE_DEC, BASE_BAD_HIGH, BASE_AUTO, BASE_HEX, BASE_DEC};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, decimal base from reset
        push_stray(CH_W'(CH_DIG0 + 5));                 // nothing open yet
        open_string(CH_MINUS);
        push_char(CH_W'(CH_DIG0 + 7));
        push_char(MAX_CODE);                            // top code point ends it
        open_string(CH_TAB);
        push_char(CH_W'(CH_DIG0 + 1));
        open_string(CH_PLUS);                           // restart mid-string
        push_char(CH_DIG9);
        push_char(CH_NUL);
        open_string(CH_LO_X);                           // no digits
        open_string(CH_NUL);
        open_string(CH_CR);
        push_char(CH_SPACE);
        push_char(CH_DIG0);
        push_char(CH_W'(CH_DIG0 + 1));
        push_char(CH_LO_Z);
        wait_drained();

        // directed, auto-detected base
        write_base(BASE_AUTO);
        open_string(CH_DIG0);                           // bare hex prefix
        push_char(CH_LO_X);
        push_char(CH_W'(CH_LO_A + 6));
        open_string(CH_DIG0);                           // octal
        push_char(CH_W'(CH_DIG0 + 1));
        push_char(CH_W'(CH_DIG0 + 7));
        push_char(CH_W'(CH_DIG0 + 8));
        open_string(CH_DIG0);
        push_char(CH_UP_X);
        push_char(CH_W'(CH_LO_A + 5));
        push_char(CH_W'(CH_UP_A + 5));
        push_char(CH_NUL);
        wait_drained();

        // random phases over bases and handshake pressure
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_base(phase_base[p]);
            target = str_chars + PHASE_CHARS;
            while (str_chars < target) begin
                if ($urandom_range(0, 4) == 0) push_noise();
                else push_number(phase_base[p]);
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
